[rtl/fys_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fys_pkg;

	// Generator constants and the seed register's reset value.
	localparam logic [63:0] LCG_MUL    = 64'd6364136223846793005;
	localparam logic [63:0] LCG_INC    = 64'd1442695040888963407;
	localparam logic [63:0] SEED_RESET = 64'h5c37d12f4a9b6e83;

	// Controller states.
	typedef enum logic [3:0] {
		ST_FILL,
		ST_SEED,
		ST_CHK,
		ST_MUL0,
		ST_MUL1,
		ST_MUL2,
		ST_ADD,
		ST_DIV,
		ST_RDA,
		ST_RDB,
		ST_WRA,
		ST_WRB,
		ST_ORD,
		ST_OHOLD
	} fys_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_in;
		logic seed;
		logic mul0;
		logic mul1;
		logic mul2;
		logic add_inc;
		logic div_step;
		logic rd_a;
		logic rd_b;
		logic wr_a;
		logic wr_b;
		logic out_rd;
		logic out_next;
		logic run_done;
	} fys_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic fill_end;
		logic i_le1;
		logic div_done;
		logic out_last;
	} fys_stat_t;

endpackage

`default_nettype wire

[rtl/lcg_fisher_yates_shuffler.sv]
// A run is shuffled after its last input transfer and then emitted; each swap runs the
// multiply steps MUL0, MUL1 and MUL2, one add, 64 remainder steps, two table reads and two writes.
// Throughput: one input per cycle while filling; each result is read, then held until taken.
// Inputs are refused while a run is shuffled or emitted; the single-port table sets that.
// Reset (arst_n low, asynchronous): the run is emptied and the seed returns to its default.
`timescale 1ns / 1ps
`default_nettype none

module lcg_fisher_yates_shuffler #(
	parameter int TABLE_DEPTH = 64,
	parameter int ENTRY_WIDTH = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [63:0] cfg_wr_data,   // shuffle_seed
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] entry_value
	input  wire logic        s_axis_tlast,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [15:0] shuffled_value
	output logic             m_axis_tlast
);
	import fys_pkg::*;

	fys_cmd_t  cmd;
	fys_stat_t stat;

	fys_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tlast  (s_axis_tlast),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	fys_dp #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_value    (s_axis_tdata),
		.out_value   (m_axis_tdata),
		.out_last    (m_axis_tlast),
		.cmd         (cmd),
		.stat        (stat)
	);

	// Input and output sides are never open together.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input and output open at once");

	// A transfer flagged last closes the run.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("run not closed after last input");

	// After the final result the block returns to filling.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready && !m_axis_tvalid)
		else $error("block not back to filling after last result");

endmodule

`default_nettype wire

[rtl/fys_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module fys_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	input  wire logic              s_tlast,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	input  wire fys_pkg::fys_stat_t stat,
	output fys_pkg::fys_cmd_t      cmd
);
	import fys_pkg::*;

	fys_state_t state_q, state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_FILL;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		case (state_q)
			ST_FILL: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.wr_in = 1'b1;
					if (s_tlast || stat.fill_end) begin
						state_d = ST_SEED;
					end
				end
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
				state_d  = ST_CHK;
			end
			ST_CHK: begin
				state_d = stat.i_le1 ? ST_ORD : ST_MUL0;
			end
			ST_MUL0: begin
				cmd.mul0 = 1'b1;
				state_d  = ST_MUL1;
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_ADD;
			end
			ST_ADD: begin
				cmd.add_inc = 1'b1;
				state_d     = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = ST_RDA;
				end
			end
			ST_RDA: begin
				cmd.rd_a = 1'b1;
				state_d  = ST_RDB;
			end
			ST_RDB: begin
				cmd.rd_b = 1'b1;
				state_d  = ST_WRA;
			end
			ST_WRA: begin
				cmd.wr_a = 1'b1;
				state_d  = ST_WRB;
			end
			ST_WRB: begin
				cmd.wr_b = 1'b1;
				state_d  = ST_CHK;
			end
			ST_ORD: begin
				cmd.out_rd = 1'b1;
				state_d    = ST_OHOLD;
			end
			ST_OHOLD: begin
				m_tvalid = 1'b1;
				if (m_tready) begin
					if (stat.out_last) begin
						cmd.run_done = 1'b1;
						state_d      = ST_FILL;
					end else begin
						cmd.out_next = 1'b1;
						state_d      = ST_ORD;
					end
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

endmodule

`default_nettype wire

[rtl/fys_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module fys_dp #(
	parameter int TABLE_DEPTH = 64,
	parameter int ENTRY_WIDTH = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [63:0]       cfg_wr_data,
	input  wire logic [15:0]       in_value,
	output logic [15:0]            out_value,
	output logic                   out_last,
	input  wire fys_pkg::fys_cmd_t cmd,
	output fys_pkg::fys_stat_t     stat
);
	import fys_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [ENTRY_WIDTH-1:0] mem [TABLE_DEPTH];
	logic [ENTRY_WIDTH-1:0] rd_q;
	logic [ENTRY_WIDTH-1:0] tmp_q;
	logic [ENTRY_WIDTH-1:0] wdata;
	logic [AW-1:0]          addr;
	logic                   we;

	logic [63:0]   seed_q;
	logic [63:0]   lcg_q;
	logic [63:0]   acc_q;
	logic [63:0]   dq_q;
	logic [63:0]   prod;
	logic [63:0]   next_s;
	logic [31:0]   mul_a;
	logic [31:0]   mul_b;
	logic [CW-1:0] fill_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] rem_q;
	logic [CW:0]   rem_sh;
	logic [5:0]    cnt_q;
	logic [AW-1:0] k_q;
	logic [AW-1:0] i_m1;
	logic [AW-1:0] j_idx;

	assign i_m1  = AW'(i_q - CW'(1));
	assign j_idx = rem_q[AW-1:0];

	// Table port: one address per cycle, chosen by the current command.
	always_comb begin
		addr  = k_q;
		we    = 1'b0;
		wdata = rd_q;
		if (cmd.wr_in) begin
			addr  = fill_q[AW-1:0];
			we    = 1'b1;
			wdata = ENTRY_WIDTH'({{ENTRY_WIDTH{1'b0}}, in_value});
		end else if (cmd.rd_a) begin
			addr = i_m1;
		end else if (cmd.wr_a) begin
			addr  = i_m1;
			we    = 1'b1;
			wdata = rd_q;
		end else if (cmd.rd_b) begin
			addr = j_idx;
		end else if (cmd.wr_b) begin
			addr  = j_idx;
			we    = 1'b1;
			wdata = tmp_q;
		end
	end

	// Entry table with registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rd_q <= mem[addr];
		if (cmd.rd_b) begin
			tmp_q <= rd_q;
		end
	end

	// Shared 32x32 multiplier for the three partial products of s * MUL, plus the increment add and remainder shift.
	always_comb begin
		mul_a  = cmd.mul2 ? lcg_q[63:32] : lcg_q[31:0];
		mul_b  = cmd.mul1 ? LCG_MUL[63:32] : LCG_MUL[31:0];
		prod   = 64'(mul_a) * 64'(mul_b);
		next_s = acc_q + LCG_INC;
		rem_sh = {rem_q, dq_q[63]};
	end

	// Generator, remainder unit and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= SEED_RESET;
			lcg_q  <= '0;
			acc_q  <= '0;
			dq_q   <= '0;
			rem_q  <= '0;
			cnt_q  <= '0;
			fill_q <= '0;
			i_q    <= '0;
			k_q    <= '0;
		end else begin
			if (cfg_wr_en) begin
				seed_q <= cfg_wr_data;
			end
			if (cmd.wr_in) begin
				fill_q <= fill_q + CW'(1);
			end
			if (cmd.seed) begin
				lcg_q <= seed_q;
				i_q   <= fill_q;
			end
			if (cmd.mul0) begin
				acc_q <= prod;
			end
			if (cmd.mul1 || cmd.mul2) begin
				acc_q <= acc_q + {prod[31:0], 32'h0};
			end
			if (cmd.add_inc) begin
				lcg_q <= next_s;
				dq_q  <= next_s;
				rem_q <= '0;
				cnt_q <= '0;
			end
			// One quotient bit per cycle; only the remainder is kept.
			if (cmd.div_step) begin
				dq_q  <= {dq_q[62:0], 1'b0};
				cnt_q <= cnt_q + 6'd1;
				if (rem_sh >= {1'b0, i_q}) begin
					rem_q <= CW'(rem_sh - {1'b0, i_q});
				end else begin
					rem_q <= CW'(rem_sh);
				end
			end
			if (cmd.wr_b) begin
				i_q <= i_q - CW'(1);
			end
			if (cmd.out_next) begin
				k_q <= k_q + AW'(1);
			end
			if (cmd.run_done) begin
				k_q    <= '0;
				fill_q <= '0;
			end
		end
	end

	assign stat.fill_end = (fill_q == CW'(TABLE_DEPTH - 1));
	assign stat.i_le1    = (i_q <= CW'(1));
	assign stat.div_done = (cnt_q == 6'd63);
	assign stat.out_last = ((CW'(k_q) + CW'(1)) == fill_q);

	assign out_value = 16'({16'h0, rd_q});
	assign out_last  = stat.out_last;

endmodule

`default_nettype wire

[bench/fys_checker.sv]
`timescale 1ns / 1ps

module fys_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [63:0] cfg_wr_data,
	input  wire logic        s_axis_tvalid,
	input  wire logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,
	input  wire logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	input  wire logic [15:0] m_axis_tdata,
	input  wire logic        m_axis_tlast,
	output int               fail_count,
	output logic             busy
);
	import fys_pkg::*;

	localparam int DEPTH = 64;

	typedef struct packed {
		logic [15:0] value;
		logic        last;
	} shuffled_t;

	logic [15:0] run_table [DEPTH];
	int          run_fill;
	logic [63:0] seed_reg;
	shuffled_t   shuffled_q [$];

	// Permute the collected run with the generator and queue the emitted order.
	task automatic shuffle_and_queue(input int count);
		logic [63:0] gen;
		logic [63:0] pick;
		logic [15:0] tmp;
		shuffled_t   item;
		gen = seed_reg;
		for (int i = count; i > 1; i--) begin
			gen = gen * LCG_MUL + LCG_INC;
			pick = gen % 64'(i);
			tmp = run_table[i - 1];
			run_table[i - 1] = run_table[pick];
			run_table[pick] = tmp;
		end
		for (int k = 0; k < count; k++) begin
			item.value = run_table[k];
			item.last = (k == count - 1);
			shuffled_q = {shuffled_q, item};
		end
	endtask

	function automatic void report(input string what, input logic [15:0] exp_v,
			input logic exp_l, input logic [15:0] got_v, input logic got_l);
		if (fail_count < 10)
			$display("%0t: %s: expected value %h last %b, got value %h last %b",
				$realtime, what, exp_v, exp_l, got_v, got_l);
		fail_count++;
	endfunction

	// Track input transfers, configuration writes and output transfers.
	always @(posedge clk or negedge arst_n) begin
		shuffled_t want;
		if (!arst_n) begin
			run_fill = 0;
			seed_reg = SEED_RESET;
			shuffled_q.delete();
			fail_count = 0;
		end else begin
			if (cfg_wr_en)
				seed_reg = cfg_wr_data;
			if (s_axis_tvalid && s_axis_tready) begin
				run_table[run_fill] = s_axis_tdata;
				run_fill = run_fill + 1;
				if (s_axis_tlast || run_fill == DEPTH) begin
					shuffle_and_queue(run_fill);
					run_fill = 0;
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (shuffled_q.size() == 0) begin
					report("unexpected transfer", '0, 1'b0, m_axis_tdata, m_axis_tlast);
				end else begin
					want = shuffled_q.pop_front();
					if (want.value !== m_axis_tdata || want.last !== m_axis_tlast)
						report("mismatch", want.value, want.last, m_axis_tdata,
							m_axis_tlast);
				end
			end
		end
		busy = (shuffled_q.size() != 0) || (run_fill != 0);
	end

	// Leftover expectations are reported by the top through busy.
endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [63:0] cfg_wr_data = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic        m_axis_tlast;
	int          fail_count;
	logic        busy;
	logic        hold_off = 1'b0;
	int          sent = 0;

	always #4 clk = ~clk;

	lcg_fisher_yates_shuffler uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	fys_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.fail_count(fail_count), .busy(busy)
	);

	// Mostly short gaps, now and then a long one; some stretches with none.
	function automatic int gap_len(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one entry and hold it until the block takes it.
	task automatic send_entry(input logic [15:0] v, input logic l, input bit quiet);
		int gap;
		gap = gap_len(quiet);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		s_axis_tlast <= l;
		do @(negedge clk); while (!s_axis_tready);
		@(posedge clk);
		sent++;
	endtask

	task automatic send_run(input int len, input bit close, input bit quiet);
		for (int k = 0; k < len; k++)
			send_entry(16'($urandom), close && (k == len - 1), quiet);
	endtask

	// Let the block drain fully, then write the seed.
	task automatic write_seed(input logic [63:0] v);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait (!busy);
		repeat (10) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Output side: random stalls, plus one long hold-off on request.
	initial begin
		int stall;
		bit quiet;
		quiet = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end else if ($urandom_range(0, 199) == 0) begin
				quiet = !quiet;
			end
			stall = gap_len(quiet);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	initial begin
		#8ms;
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int len;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: single-entry runs at the extremes, a pair and a run of three with the reset
		// seed, runs under seeds of zero and all ones, and a run closed only by filling the table.
		send_entry(16'h0000, 1'b1, 1'b0);
		send_entry(16'hffff, 1'b1, 1'b0);
		send_entry(16'h5555, 1'b0, 1'b0);
		send_entry(16'haaaa, 1'b1, 1'b0);
		send_run(3, 1'b1, 1'b1);
		write_seed(64'd0);
		send_run(5, 1'b1, 1'b0);
		write_seed('1);
		send_run(6, 1'b1, 1'b0);
		send_run(64, 1'b0, 1'b1);

		// Wait until the full run has drained, then hold the receiver off
		// long enough that the next run's results back up and stall the input.
		s_axis_tvalid <= 1'b0;
		wait (!busy);
		@(posedge clk);
		hold_off = 1'b1;
		send_run(20, 1'b1, 1'b1);
		send_run(4, 1'b1, 1'b1);
		write_seed(64'($urandom) << 32 | 64'($urandom));

		// Random runs, mostly short; occasionally a full table and reseeds.
		while (sent < 370) begin
			case ($urandom_range(0, 19))
				0: len = 64;
				1: len = $urandom_range(20, 63);
				default: len = $urandom_range(1, 8);
			endcase
			send_run(len, len != 64 || $urandom_range(0, 1), 1'b0);
			if ($urandom_range(0, 9) == 0)
				write_seed(64'($urandom) << 32 | 64'($urandom));
		end

		s_axis_tvalid <= 1'b0;
		wait (!busy);
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
